### rtl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, including during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// Checked at every rising clock edge outside reset.
`define ASSERT_RUN(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

### rtl/eau_pkg.sv
// Types and constants shared by the extended arithmetic unit modules.
package eau_pkg;

   localparam int WordW = 16;
   localparam int IdxW = 3;
   localparam int DivSteps = 2 * WordW;
   localparam int CntW = $clog2(DivSteps);
   localparam int ShCntW = 6;

   localparam logic FUNC_READ = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   localparam logic [IdxW-1:0] IDX_DIV = 3'd0;
   localparam logic [IdxW-1:0] IDX_AC = 3'd1;
   localparam logic [IdxW-1:0] IDX_MQ = 3'd2;
   localparam logic [IdxW-1:0] IDX_MUL = 3'd3;
   localparam logic [IdxW-1:0] IDX_SHIFT_A = 3'd6;
   localparam logic [IdxW-1:0] IDX_SHIFT_B = 3'd7;

   localparam logic [ShCntW:0] SHIFT_SPAN = 7'd64;

   typedef struct packed {
      logic capture;
      logic div_step;
      logic div_finish;
   } cmd_type;

   typedef struct packed {
      logic divisor_nonzero;
   } stat_type;

endpackage

### rtl/eau_ctrl.sv
// Controller: item handshake, divide sequencing and result valid.
module eau_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_func,
   input  logic [eau_pkg::IdxW-1:0]  req_reg_index,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output eau_pkg::cmd_type          cmd,
   input  eau_pkg::stat_type         stat
);
   import eau_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIX
   } state_type;

   state_type       state_ff;
   logic [CntW-1:0] cnt_ff;
   logic            rsp_valid_ff;
   logic            accept;
   logic            start_div;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept = req_valid && req_ready;
   assign start_div = accept && (req_func == FUNC_WRITE) && (req_reg_index == IDX_DIV)
                      && stat.divisor_nonzero;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.capture = accept;
   assign cmd.div_step = (state_ff == ST_DIV);
   assign cmd.div_finish = (state_ff == ST_FIX);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept || (rsp_valid_ff && !rsp_ready);
         case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (start_div) begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CntW'(DivSteps - 1)) begin
                  state_ff <= ST_FIX;
               end
            end
            ST_FIX: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### rtl/eau_dp.sv
// Datapath: AC and MQ registers, multiplier, shifter and radix-2 divider.
module eau_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  eau_pkg::cmd_type          cmd,
   output eau_pkg::stat_type         stat,
   input  logic                      req_func,
   input  logic [eau_pkg::IdxW-1:0]  req_reg_index,
   input  logic [eau_pkg::WordW-1:0] req_write_data,
   output logic [eau_pkg::WordW-1:0] rsp_read_data
);
   import eau_pkg::*;

   logic [WordW-1:0]   ac_ff, ac_in;
   logic [WordW-1:0]   mq_ff, mq_in;
   logic [WordW-1:0]   rd_ff, rd_in;
   logic [WordW-1:0]   rem_ff, rem_in;
   logic [2*WordW-1:0] quo_ff, quo_in;
   logic [WordW-1:0]   dvs_ff, dvs_in;
   logic               qneg_ff, qneg_in;
   logic               rneg_ff, rneg_in;

   logic [2*WordW-1:0] joined;
   logic [2*WordW-1:0] dvd_mag;
   logic [2*WordW-1:0] product;
   logic [2*WordW-1:0] sh_arith;
   logic [2*WordW-1:0] shifted;
   logic [ShCntW-1:0]  sh_cnt;
   logic [ShCntW-1:0]  sh_right;
   logic [WordW:0]     trial;
   logic [WordW:0]     diff;
   logic [2*WordW-1:0] quo_fix;
   logic [WordW-1:0]   rem_fix;
   logic               dneg;
   logic               sneg;

   assign stat.divisor_nonzero = (req_write_data != '0);
   assign rsp_read_data = rd_ff;

   assign joined = {ac_ff, mq_ff};
   assign dneg = joined[2*WordW-1];
   assign sneg = req_write_data[WordW-1];
   assign dvd_mag = dneg ? (~joined + 1'b1) : joined;
   assign product = $signed(mq_ff) * $signed(req_write_data);

   assign sh_cnt = req_write_data[ShCntW-1:0];
   assign sh_right = ShCntW'(SHIFT_SPAN - {1'b0, sh_cnt});
   assign sh_arith = $signed(joined) >>> sh_right;
   assign shifted = sh_cnt[ShCntW-1] ? sh_arith : (joined << sh_cnt[ShCntW-2:0]);

   assign trial = {rem_ff, quo_ff[2*WordW-1]};
   assign diff = trial - {1'b0, dvs_ff};
   assign quo_fix = qneg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign rem_fix = rneg_ff ? (~rem_ff + 1'b1) : rem_ff;

   always_comb begin
      ac_in = ac_ff;
      mq_in = mq_ff;
      rd_in = rd_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      qneg_in = qneg_ff;
      rneg_in = rneg_ff;
      if (cmd.capture) begin
         rd_in = '0;
         if (req_func == FUNC_READ) begin
            if (req_reg_index == IDX_AC) begin
               rd_in = ac_ff;
            end else if (req_reg_index == IDX_MQ) begin
               rd_in = mq_ff;
            end
         end else begin
            case (req_reg_index)
               IDX_DIV: begin
                  if (req_write_data == '0) begin
                     ac_in = '0;
                     mq_in = '0;
                  end
                  rem_in = '0;
                  quo_in = dvd_mag;
                  dvs_in = sneg ? (~req_write_data + 1'b1) : req_write_data;
                  qneg_in = dneg ^ sneg;
                  rneg_in = dneg;
               end
               IDX_AC: begin
                  ac_in = req_write_data;
               end
               IDX_MQ: begin
                  mq_in = req_write_data;
                  ac_in = {WordW{req_write_data[WordW-1]}};
               end
               IDX_MUL: begin
                  {ac_in, mq_in} = product;
               end
               IDX_SHIFT_A, IDX_SHIFT_B: begin
                  {ac_in, mq_in} = shifted;
               end
               default: begin
               end
            endcase
         end
      end else if (cmd.div_step) begin
         if (!diff[WordW]) begin
            rem_in = diff[WordW-1:0];
         end else begin
            rem_in = trial[WordW-1:0];
         end
         quo_in = {quo_ff[2*WordW-2:0], !diff[WordW]};
      end else if (cmd.div_finish) begin
         mq_in = quo_fix[WordW-1:0];
         ac_in = rem_fix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ac_ff <= '0;
         mq_ff <= '0;
      end else begin
         ac_ff <= ac_in;
         mq_ff <= mq_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= rd_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
   end

endmodule

### rtl/extended_arithmetic_unit.sv
// Extended arithmetic unit: AC/MQ registers with multiply, divide and shift.
// Every item returns its result in the cycle after acceptance through an output register.
// Reads, loads, multiply and shift finish at once: one item per cycle while rsp_ready is high.
// A nonzero divide keeps req_ready low through 32 steps of the radix-2 subtractor and
// then the sign-correction state, so no new item is taken until the divide is done.
// Synchronous reset clears AC, MQ, the controller and the result valid.
module extended_arithmetic_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_func,
   input  logic [eau_pkg::IdxW-1:0]  req_reg_index,
   input  logic [eau_pkg::WordW-1:0] req_write_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [eau_pkg::WordW-1:0] rsp_read_data
);
   import eau_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   eau_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_reg_index (req_reg_index),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd),
      .stat          (stat)
   );

   eau_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_func       (req_func),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .rsp_read_data  (rsp_read_data)
   );

endmodule

### rtl/eau_checker.sv
// Port-level checker for the extended arithmetic unit and its bind.
`include "assert_macros.svh"

module eau_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_func,
   input logic [eau_pkg::IdxW-1:0]  req_reg_index,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [eau_pkg::WordW-1:0] rsp_read_data
);
   import eau_pkg::*;

   logic req_acc;
   logic odd_read;
   logic stall;
   logic wr_acc;
   logic odd_acc;
   logic rsp_zero;

   assign req_acc = req_valid && req_ready;
   assign odd_read = (req_func == FUNC_READ) && (req_reg_index != IDX_AC)
                     && (req_reg_index != IDX_MQ);
   assign stall = rsp_valid && !rsp_ready;
   assign wr_acc = req_acc && (req_func == FUNC_WRITE);
   assign odd_acc = req_acc && odd_read;
   assign rsp_zero = (rsp_read_data == '0);

   `ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")
   `ASSERT_RUN(a_rsp_hold, clock, reset, stall |=> rsp_valid && $stable(rsp_read_data), "item lost")
   `ASSERT_RUN(a_write_zero, clock, reset, wr_acc |=> rsp_valid && rsp_zero, "write returned data")
   `ASSERT_RUN(a_read_zero, clock, reset, odd_acc |=> rsp_valid && rsp_zero, "odd read returned data")
   `ASSERT_RUN(a_no_overrun, clock, reset, stall |-> !req_ready, "item accepted while stalled")

endmodule

bind extended_arithmetic_unit eau_checker u_eau_checker (.*);
